@@ sv/u8off_pkg.sv @@
// Shared types and register codes for the UTF-8 unit count to byte offset block.
`default_nettype none

package u8off_pkg;

	// Configuration register indexes
	localparam logic REG_TARGET_COUNT = 1'b0;
	localparam logic REG_COUNT_UTF16  = 1'b1;

	// Controller states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;   // take the accepted word into the buffer
		logic step;   // consume the sequence at the head of the buffer
		logic emit;   // write the result into the output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic live_next;  // the incoming word belongs to an open string
		logic emit_req;   // a result is due now
		logic stop;       // nothing more to decide until the next word
	} status_t;

endpackage

`default_nettype wire

@@ sv/utf8_unit_count_to_byte_offset_top.sv @@
// Top level: UTF-8 unit count to byte offset, controller plus datapath.
`default_nettype none

// Takes UTF-8 text a byte per word and returns, at most once per string, the byte offset
// at which target_count codepoints (or UTF-16 units when count_utf16_units is set) are
// used up, or the string length with target_reached low if a NUL or end_of_text comes
// first. Malformed sequences count as one stray byte each. Each byte is accepted, then
// the four-byte buffer consumes each sequence the byte lets it decide (up to four), one
// sequence per cycle, and a closing step returns to accept; when it emits a result, it
// first waits for the output word to be taken. A result waits in its output register
// while the next byte is accepted. Configuration writes take effect at the next
// first_byte (count_utf16_units at once).
module utf8_unit_count_to_byte_offset_top #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_write_en,
	input  wire                    cfg_index,
	input  wire [15:0]             cfg_data,
	input  wire                    text_valid,
	output logic                   text_ready,
	input  wire [7:0]              text_byte,
	input  wire                    first_byte,
	input  wire                    end_of_text,
	output logic                   result_valid,
	input  wire                    result_ready,
	output logic [COUNT_WIDTH-1:0] byte_offset,
	output logic                   target_reached
);
	import u8off_pkg::*;

	cmd_t    cmd;
	status_t status;

	u8off_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	u8off_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.text_byte      (text_byte),
		.first_byte     (first_byte),
		.end_of_text    (end_of_text),
		.cmd            (cmd),
		.status         (status),
		.byte_offset    (byte_offset),
		.target_reached (target_reached)
	);

endmodule

`default_nettype wire

@@ sv/u8off_dp.sv @@
// Datapath: configuration registers, byte buffer, sequence check, counters and result register.
`default_nettype none

module u8off_dp #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_write_en,
	input  wire                    cfg_index,
	input  wire [15:0]             cfg_data,
	input  wire [7:0]              text_byte,
	input  wire                    first_byte,
	input  wire                    end_of_text,
	input  u8off_pkg::cmd_t        cmd,
	output u8off_pkg::status_t     status,
	output logic [COUNT_WIDTH-1:0] byte_offset,
	output logic                   target_reached
);
	import u8off_pkg::*;

	localparam logic [7:0]  LEAD4_MASK = 8'hF8;
	localparam logic [7:0]  LEAD4_VAL  = 8'hF0;
	localparam logic [7:0]  LEAD3_MASK = 8'hF0;
	localparam logic [7:0]  LEAD3_VAL  = 8'hE0;
	localparam logic [7:0]  LEAD2_MASK = 8'hE0;
	localparam logic [7:0]  LEAD2_VAL  = 8'hC0;
	localparam logic [7:0]  CONT_MASK  = 8'hC0;
	localparam logic [7:0]  CONT_VAL   = 8'h80;
	localparam logic [15:0] MIN3       = 16'h0800;
	localparam logic [15:0] SURR_LO    = 16'hD800;
	localparam logic [15:0] SURR_HI    = 16'hDFFF;
	localparam logic [20:0] MIN4       = 21'h10000;
	localparam logic [20:0] MAX_CP     = 21'h10FFFF;

	logic [15:0]            target_q;
	logic                   utf16_q;
	logic [7:0]             pb_q [4];
	logic [2:0]             pc_q;
	logic [COUNT_WIDTH-1:0] ul_q;
	logic [COUNT_WIDTH-1:0] pos_q;
	logic                   fin_q;
	logic                   at_end_q;

	logic [COUNT_WIDTH-1:0] ul_load;
	logic                   live_next;
	logic                   append;
	logic [2:0]             pc_base;
	logic [2:0]             decl;
	logic [2:0]             hl;
	logic                   done;
	logic [15:0]            cp3;
	logic [20:0]            cp4;
	logic [1:0]             units;
	logic                   ul_zero;
	logic                   short_units;
	logic                   reached;
	logic [COUNT_WIDTH:0]   pos_sum;
	logic [COUNT_WIDTH-1:0] pos_next;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			utf16_q  <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_TARGET_COUNT: target_q <= cfg_data;
				REG_COUNT_UTF16:  utf16_q  <= cfg_data[0];
			endcase
		end
	end

	// Decode the accepted word
	assign ul_load   = COUNT_WIDTH'(target_q);
	assign live_next = first_byte | ~fin_q;
	assign append    = (text_byte != 8'h00) & live_next & ~(first_byte & (ul_load == '0));
	assign pc_base   = first_byte ? 3'd0 : pc_q;

	// Judge the sequence at the head of the buffer: 1..4 bytes, 0 if undecided
	always_comb begin
		cp3 = {pb_q[0][3:0], pb_q[1][5:0], pb_q[2][5:0]};
		cp4 = {pb_q[0][2:0], pb_q[1][5:0], pb_q[2][5:0], pb_q[3][5:0]};
		if ((pb_q[0] & LEAD4_MASK) == LEAD4_VAL) begin
			decl = 3'd4;
		end else if ((pb_q[0] & LEAD3_MASK) == LEAD3_VAL) begin
			decl = 3'd3;
		end else if ((pb_q[0] & LEAD2_MASK) == LEAD2_VAL) begin
			decl = 3'd2;
		end else begin
			decl = 3'd1;
		end
		hl   = decl;
		done = (decl == 3'd1);
		for (int i = 1; i < 4; i++) begin
			if (!done && (3'(i) < decl)) begin
				if (3'(i) >= pc_q) begin
					hl   = at_end_q ? 3'd1 : 3'd0;
					done = 1'b1;
				end else if ((pb_q[i] & CONT_MASK) != CONT_VAL) begin
					hl   = 3'd1;
					done = 1'b1;
				end
			end
		end
		// Reject overlong forms, surrogates and values past the last codepoint
		if (!done) begin
			if (decl == 3'd2) begin
				if (pb_q[0][4:1] == 4'd0) hl = 3'd1;
			end else if (decl == 3'd3) begin
				if (cp3 < MIN3 || (cp3 >= SURR_LO && cp3 <= SURR_HI)) hl = 3'd1;
			end else begin
				if (cp4 < MIN4 || cp4 > MAX_CP) hl = 3'd1;
			end
		end
	end

	// Count units and decide what the next drain step does
	assign units       = (utf16_q && hl == 3'd4) ? 2'd2 : 2'd1;
	assign ul_zero     = (ul_q == '0);
	assign short_units = (ul_q < COUNT_WIDTH'(units));
	assign reached     = ul_zero | (pc_q != 3'd0);

	assign status.live_next = live_next;
	assign status.emit_req  = ul_zero
		| ((pc_q != 3'd0) & (hl != 3'd0) & short_units)
		| ((pc_q == 3'd0) & at_end_q);
	assign status.stop      = ~status.emit_req
		& (((pc_q == 3'd0) & ~at_end_q) | ((pc_q != 3'd0) & (hl == 3'd0)));

	// Saturating position advance
	assign pos_sum  = {1'b0, pos_q} + (COUNT_WIDTH + 1)'(hl);
	assign pos_next = pos_sum[COUNT_WIDTH] ? '1 : pos_sum[COUNT_WIDTH-1:0];

	// Control state of the string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			ul_q     <= '0;
			pos_q    <= '0;
			fin_q    <= 1'b1;
			at_end_q <= 1'b0;
		end else if (cmd.load) begin
			if (first_byte) begin
				pos_q <= '0;
				ul_q  <= ul_load;
				fin_q <= 1'b0;
			end
			pc_q     <= pc_base + {2'b00, append};
			at_end_q <= (text_byte == 8'h00) | end_of_text;
		end else if (cmd.step) begin
			ul_q  <= ul_q - COUNT_WIDTH'(units);
			pos_q <= pos_next;
			pc_q  <= pc_q - hl;
		end else if (cmd.emit) begin
			fin_q <= 1'b1;
		end
	end

	// Append or shift the buffered bytes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (append) pb_q[pc_base[1:0]] <= text_byte;
		end else if (cmd.step) begin
			unique case (hl)
				3'd1: begin
					pb_q[0] <= pb_q[1];
					pb_q[1] <= pb_q[2];
					pb_q[2] <= pb_q[3];
				end
				3'd2: begin
					pb_q[0] <= pb_q[2];
					pb_q[1] <= pb_q[3];
				end
				3'd3: pb_q[0] <= pb_q[3];
				default: ;
			endcase
		end
	end

	// Hold the result word
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			byte_offset    <= pos_q;
			target_reached <= reached;
		end
	end

endmodule

`default_nettype wire

@@ sv/u8off_ctrl.sv @@
// Controller: sequences accept, drain steps and the output word handshake.
`default_nettype none

module u8off_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                text_valid,
	output logic               text_ready,
	output logic               result_valid,
	input  wire                result_ready,
	input  u8off_pkg::status_t status,
	output u8off_pkg::cmd_t    cmd
);
	import u8off_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_free;

	assign text_ready = (state_q == ST_IDLE);
	assign out_free   = ~result_valid | result_ready;

	// Pick the command and next state
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (text_valid) begin
					cmd.load = 1'b1;
					if (status.live_next) state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.emit_req) begin
					if (out_free) begin
						cmd.emit = 1'b1;
						state_d  = ST_IDLE;
					end
				end else if (status.stop) begin
					state_d = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance state and track the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ dv/utf8_offset_checker.sv @@
// Scoreboard for the UTF-8 offset block: predicts each string's result word and checks it.
module utf8_offset_checker #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_write_en,
	input  wire                   cfg_index,
	input  wire [15:0]            cfg_data,
	input  wire                   text_valid,
	input  wire                   text_ready,
	input  wire [7:0]             text_byte,
	input  wire                   first_byte,
	input  wire                   end_of_text,
	input  wire                   result_valid,
	input  wire                   result_ready,
	input  wire [COUNT_WIDTH-1:0] byte_offset,
	input  wire                   target_reached,
	output int unsigned           mismatches,
	output int unsigned           awaiting,
	output int unsigned           checked
);
	import u8off_pkg::*;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] offset;
		logic                   reached;
	} offset_result_t;

	// Results owed by the block, oldest first
	offset_result_t offsets_due[$];
	offset_result_t want;

	// Shadow copy of the registers and the scan state
	logic [15:0]            target_units;
	logic                   utf16_mode;
	logic [7:0]             held [4];
	logic [2:0]             held_cnt;
	logic [COUNT_WIDTH-1:0] units_left;
	logic [COUNT_WIDTH-1:0] scan_pos;
	logic                   scan_done;
	int unsigned            fail_n;
	int unsigned            match_n;

	// Close the current string with the given outcome
	function automatic void post_result(input logic reached);
		offsets_due.push_back('{offset: scan_pos, reached: reached});
		scan_done = 1'b1;
	endfunction

	// Length of the sequence at the head of the held bytes; 0 means undecided yet
	function automatic logic [2:0] seq_len(input logic at_end);
		logic [7:0]  lead;
		logic [20:0] cp;
		int          declared;
		int          i;
		lead = held[0];
		if ((lead & 8'hF8) == 8'hF0) declared = 4;
		else if ((lead & 8'hF0) == 8'hE0) declared = 3;
		else if ((lead & 8'hE0) == 8'hC0) declared = 2;
		else return 3'd1;
		for (i = 1; i < declared; i++) begin
			if (i >= held_cnt) return at_end ? 3'd1 : 3'd0;
			if (held[i][7:6] != 2'b10) return 3'd1;
		end
		// reject overlong forms
		case (declared)
			2: begin
				cp = {10'd0, lead[4:0], held[1][5:0]};
				if (cp < 21'h80) return 3'd1;
			end
			3: begin
				cp = {5'd0, lead[3:0], held[1][5:0], held[2][5:0]};
				if (cp < 21'h800) return 3'd1;
			end
			default: begin
				cp = {lead[2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
				if (cp < 21'h10000) return 3'd1;
			end
		endcase
		// reject surrogates and values past the last plane
		if (cp >= 21'hD800 && cp <= 21'hDFFF) return 3'd1;
		if (cp > 21'h10FFFF) return 3'd1;
		return 3'(declared);
	endfunction

	// Consume every decidable sequence from the held bytes
	function automatic void consume_held(input logic at_end);
		logic [2:0]           len;
		logic [1:0]           units;
		logic [COUNT_WIDTH:0] sum;
		int                   i;
		while (held_cnt != 0 && !scan_done) begin
			len = seq_len(at_end);
			if (len == 0) break;
			if (len > held_cnt) len = held_cnt;
			units = (utf16_mode && len == 3'd4) ? 2'd2 : 2'd1;
			if (units_left < COUNT_WIDTH'(units)) begin
				// next codepoint would split a surrogate pair
				post_result(1'b1);
			end else begin
				units_left = units_left - COUNT_WIDTH'(units);
				sum = {1'b0, scan_pos} + (COUNT_WIDTH + 1)'(len);
				scan_pos = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
				for (i = 0; i + len < held_cnt; i++)
					held[i] = held[i + len];
				held_cnt = held_cnt - len;
				if (units_left == 0) post_result(1'b1);
			end
		end
	endfunction

	// Advance the scan by one accepted text word
	function automatic void advance_scan(input logic [7:0] b, input logic f, input logic e);
		if (f) begin
			held_cnt   = 3'd0;
			scan_pos   = '0;
			units_left = COUNT_WIDTH'(target_units);
			scan_done  = 1'b0;
			if (units_left == 0) post_result(1'b1);
		end
		if (!scan_done) begin
			if (b == 8'h00) begin
				consume_held(1'b1);
				if (!scan_done) post_result(1'b0);
			end else begin
				if (held_cnt < 4) begin
					held[held_cnt[1:0]] = b;
					held_cnt = held_cnt + 1'b1;
				end
				consume_held(e);
				if (!scan_done && e) post_result(1'b0);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offsets_due.delete();
			target_units = '0;
			utf16_mode   = 1'b0;
			held_cnt     = 3'd0;
			units_left   = '0;
			scan_pos     = '0;
			scan_done    = 1'b1;
			fail_n       = 0;
			match_n      = 0;
			mismatches  <= 0;
			awaiting    <= 0;
			checked     <= 0;
		end else begin
			// track register writes
			if (cfg_write_en) begin
				if (cfg_index == REG_TARGET_COUNT) target_units = cfg_data;
				else if (cfg_index == REG_COUNT_UTF16) utf16_mode = cfg_data[0];
			end
			// check the result word against the oldest prediction
			if (result_valid && result_ready) begin
				if (offsets_due.size() == 0) begin
					$error("unexpected result word: byte_offset %0d target_reached %0d",
						byte_offset, target_reached);
					fail_n++;
				end else begin
					want = offsets_due.pop_front();
					if (byte_offset !== want.offset) begin
						$error("byte_offset mismatch: expected %0d, actual %0d",
							want.offset, byte_offset);
						fail_n++;
					end
					if (target_reached !== want.reached) begin
						$error("target_reached mismatch: expected %0d, actual %0d",
							want.reached, target_reached);
						fail_n++;
					end
					match_n++;
				end
			end
			// predict from the accepted text word
			if (text_valid && text_ready)
				advance_scan(text_byte, first_byte, end_of_text);
			mismatches <= fail_n;
			awaiting   <= offsets_due.size();
			checked    <= match_n;
		end
	end

endmodule

@@ dv/tb_utf8_unit_count_to_byte_offset_top.sv @@
// Testbench top: clock, reset, text stimulus and verdict for the UTF-8 offset block.
module tb_utf8_unit_count_to_byte_offset_top;
	import u8off_pkg::*;

	localparam int COUNT_WIDTH       = 16;
	localparam int CLK_PERIOD        = 12;
	localparam int RESET_CYCLES      = 7;
	localparam int SETTLE_CYCLES     = 10;
	localparam int RX_HOLD_CYCLES    = 300;
	localparam int RANDOM_WORDS      = 1950;
	localparam int STRINGS_PER_PHASE = 24;
	localparam int LIMIT_CYCLES      = 4_000_000;

	typedef enum logic [1:0] {
		END_OPEN,
		END_NUL,
		END_EOT
	} str_end_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic                   cfg_index;
	logic [15:0]            cfg_data;
	logic                   text_valid;
	logic                   text_ready;
	logic [7:0]             text_byte;
	logic                   first_byte;
	logic                   end_of_text;
	logic                   result_valid;
	logic                   result_ready;
	logic [COUNT_WIDTH-1:0] byte_offset;
	logic                   target_reached;

	int unsigned mismatches;
	int unsigned awaiting;
	int unsigned checked;

	logic [7:0]  line_buf[$];
	int          tx_idle_pct   = 0;
	int          rx_stall_pct  = 0;
	int unsigned hold_req      = 0;
	int unsigned hold_served;
	int unsigned words_sent    = 0;
	int unsigned counted_words = 0;
	int unsigned strings_sent  = 0;
	bit          counting      = 1'b0;
	int          phase;

	utf8_unit_count_to_byte_offset_top #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.text_valid    (text_valid),
		.text_ready    (text_ready),
		.text_byte     (text_byte),
		.first_byte    (first_byte),
		.end_of_text   (end_of_text),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.byte_offset   (byte_offset),
		.target_reached(target_reached)
	);

	utf8_offset_checker #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.text_valid    (text_valid),
		.text_ready    (text_ready),
		.text_byte     (text_byte),
		.first_byte    (first_byte),
		.end_of_text   (end_of_text),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.byte_offset   (byte_offset),
		.target_reached(target_reached),
		.mismatches    (mismatches),
		.awaiting      (awaiting),
		.checked       (checked)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Result side: random stalls, plus a long hold-off on request
	initial begin
		result_ready = 1'b0;
		hold_served  = 0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_req) begin
				result_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_served++;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Run limit
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("run limit reached, %0d result words still owed", awaiting);
		$display("simulation failed");
		$finish;
	end

	// Offer one text word, after an optional idle gap, and hold it until taken
	task automatic send_word(input logic [7:0] b, input logic f, input logic e);
		int gap;
		gap = 0;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
		if (gap != 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid  <= 1'b1;
		text_byte   <= b;
		first_byte  <= f;
		end_of_text <= e;
		do @(posedge clk); while (!text_ready);
		words_sent++;
	endtask

	// Drop valid, wait for every owed result, then let the pipeline go quiet
	task automatic wait_drained();
		text_valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back; only called while the block is idle
	task automatic set_config(input logic [15:0] target, input logic utf16);
		cfg_write_en <= 1'b1;
		cfg_index    <= REG_TARGET_COUNT;
		cfg_data     <= target;
		@(posedge clk);
		cfg_index    <= REG_COUNT_UTF16;
		cfg_data     <= {15'd0, utf16};
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Send the buffered string, marking its start and, unless it is left open, its end
	task automatic send_text(input str_end_t how, input logic nul_eot);
		int n;
		int i;
		n = line_buf.size();
		for (i = 0; i < n; i++)
			send_word(line_buf[i], i == 0, how == END_EOT && i == n - 1);
		if (how == END_NUL) send_word(8'h00, n == 0, nul_eot);
		strings_sent++;
		if (counting) counted_words += n + (how == END_NUL);
	endtask

	// Append a codepoint encoded in n bytes, keeping only the first keep of them
	function automatic void put_seq(input logic [20:0] cp, input int n, input int keep);
		logic [7:0] enc [4];
		int         i;
		case (n)
			1: enc[0] = {1'b0, cp[6:0]};
			2: begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
			end
			3: begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
			end
			default: begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (i = 0; i < keep; i++) line_buf.push_back(enc[i]);
	endfunction

	// Random value in a range, leaning on both ends
	function automatic logic [20:0] pick_cp(input int unsigned lo, input int unsigned hi);
		case ($urandom_range(7))
			0: return 21'(lo);
			1: return 21'(hi);
			default: return 21'($urandom_range(hi, lo));
		endcase
	endfunction

	// Append one well-formed character or one malformed fragment
	function automatic void add_random_token();
		int          k;
		int          n;
		int unsigned lo;
		int unsigned hi;
		logic [20:0] cp;
		k  = $urandom_range(99);
		n  = $urandom_range(4, 2);
		lo = (n == 2) ? 'h80 : (n == 3) ? 'h800 : 'h10000;
		hi = (n == 2) ? 'h7FF : (n == 3) ? 'hFFFF : 'h10FFFF;
		if (k < 30) begin
			put_seq(pick_cp(1, 'h7F), 1, 1);
		end else if (k < 45) begin
			put_seq(pick_cp('h80, 'h7FF), 2, 2);
		end else if (k < 60) begin
			cp = pick_cp('h800, 'hFFFF);
			// steer clear of the surrogate range, landing on its edges
			if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = $urandom_range(1) ? 21'hD7FF : 21'hE000;
			put_seq(cp, 3, 3);
		end else if (k < 75) begin
			put_seq(pick_cp('h10000, 'h10FFFF), 4, 4);
		end else begin
			case ($urandom_range(7))
				0: line_buf.push_back(8'($urandom_range('hBF, 'h80)));
				1: put_seq(pick_cp(0, lo - 1), n, n);
				2: put_seq(pick_cp('hD800, 'hDFFF), 3, 3);
				3: put_seq(pick_cp('h110000, 'h1FFFFF), 4, 4);
				4: put_seq(pick_cp(lo, hi), n, $urandom_range(n - 1, 1));
				5: line_buf.push_back(8'($urandom_range('hFF, 'hF8)));
				6: begin
					// lead cut short by a plain byte
					put_seq(pick_cp(lo, hi), n, $urandom_range(n - 1, 1));
					line_buf.push_back(8'($urandom_range('h7F, 1)));
				end
				default: line_buf.push_back(8'($urandom_range(255, 1)));
			endcase
		end
	endfunction

	function automatic void build_random_string();
		int ntok;
		line_buf.delete();
		ntok = $urandom_range(6);
		repeat (ntok) add_random_token();
	endfunction

	// One random phase: its own register setting and idle mix
	task automatic run_random_phase(input int p);
		logic [15:0] target;
		logic        utf16;
		int          s;
		int          r;
		str_end_t    how;
		case (p % 6)
			0: target = 16'($urandom_range(6, 1));
			1: target = 16'($urandom_range(40));
			2: target = 16'hFFFF;
			3: target = 16'($urandom_range(16'hFFFF));
			4: target = 16'd1;
			default: target = 16'd0;
		endcase
		utf16 = 1'(((p / 6) + (p / 3)) % 2);
		wait_drained();
		case (p % 4)
			0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
			1: begin tx_idle_pct = 46; rx_stall_pct = 0; end
			2: begin tx_idle_pct = 0; rx_stall_pct = 46; end
			default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
		endcase
		set_config(target, utf16);
		for (s = 0; s < STRINGS_PER_PHASE; s++) begin
			// hold off the result side while text keeps coming
			if (p == 0 && s == 3) hold_req++;
			// pause the text side until all results are in
			if (p == 2 && s == 12) wait_drained();
			build_random_string();
			r = $urandom_range(99);
			if (r < 45 || line_buf.size() == 0) how = END_NUL;
			else if (r < 90) how = END_EOT;
			else how = END_OPEN;
			send_text(how, $urandom_range(4) == 0);
			// stray word between strings
			if ($urandom_range(99) < 5) send_word(8'($urandom_range(255, 1)), 1'b0, 1'b0);
		end
	endtask

	// Stimulus
	initial begin
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = REG_TARGET_COUNT;
		cfg_data     = '0;
		text_valid   = 1'b0;
		text_byte    = '0;
		first_byte   = 1'b0;
		end_of_text  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// word with no open string right out of reset
		send_word(8'hFF, 1'b0, 1'b0);
		wait_drained();

		// zero target answers at the first byte and ignores the rest
		set_config(16'd0, 1'b0);
		line_buf = '{8'h5A, 8'h7A};
		send_text(END_EOT, 1'b0);

		// target met at the last byte of a string left open
		wait_drained();
		set_config(16'd3, 1'b0);
		line_buf = '{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC};
		send_text(END_OPEN, 1'b0);

		// overlong, surrogate, past last plane, bad lead, then NUL
		wait_drained();
		set_config(16'hFFFF, 1'b0);
		line_buf = '{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hF8};
		send_text(END_NUL, 1'b0);

		// pair that would split, NUL as first byte, end of text with bytes held
		wait_drained();
		set_config(16'd1, 1'b1);
		line_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80};
		send_text(END_EOT, 1'b0);
		line_buf = {};
		send_text(END_NUL, 1'b0);
		line_buf = '{8'hF0, 8'h9F};
		send_text(END_EOT, 1'b0);

		// random strings over rotating settings and idle mixes
		phase    = 0;
		counting = 1'b1;
		while (phase < 8 || counted_words < RANDOM_WORDS) begin
			run_random_phase(phase);
			phase++;
		end

		wait_drained();
		$display("run covered %0d text words in %0d strings over %0d random phases, %0d results",
			words_sent, strings_sent, phase, checked);
		$display("modes: codepoint and UTF-16 counts, zero targets, malformed input, stalls");
		if (awaiting != 0) $error("%0d result words never arrived", awaiting);
		if (mismatches == 0 && awaiting == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ utf8_unit_count_to_byte_offset_top.f @@
sv/u8off_pkg.sv
sv/u8off_dp.sv
sv/u8off_ctrl.sv
sv/utf8_unit_count_to_byte_offset_top.sv
dv/utf8_offset_checker.sv
dv/tb_utf8_unit_count_to_byte_offset_top.sv
